/* hdl/rounded_hexagon_icon_shader_defines.svh */
// ---------------------------------------------------------------------------
// Rounded hexagon icon shader assertion macros
// Shared property forms; each expects clk and rst_n in the enclosing scope.
// ---------------------------------------------------------------------------
`ifndef ROUNDED_HEXAGON_ICON_SHADER_DEFINES_SVH
`define ROUNDED_HEXAGON_ICON_SHADER_DEFINES_SVH

// Same-cycle implication.
`define RHEX_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RHEX_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rhex_pkg.sv */
// ---------------------------------------------------------------------------
// Rounded hexagon icon shader package
// Fixed-point constants, register indexes, fill codes and shared types.
// ---------------------------------------------------------------------------
package rhex_pkg;

    // Default number of fraction bits for geometry
    localparam int COORD_BITS_DEF = 8;

    // Constants held with 16 fraction bits
    localparam logic [16:0] K_ONE    = 17'd65536;
    localparam logic [16:0] K_HALF   = 17'd32768;
    localparam logic [16:0] K_CORNER = 17'd15729;
    localparam logic [16:0] K_SQ3H   = 17'd56756;
    localparam logic [16:0] K_INVSQ3 = 17'd37837;
    localparam logic [16:0] K_TIPFIX = 17'd10138;
    localparam logic [16:0] K_RCX    = 17'd26214;
    localparam logic [16:0] K_RCY    = 17'd22938;
    localparam logic [16:0] K_RDEN   = 17'd45875;

    // Gradient fraction and divider sizing
    localparam int TFRAC     = 16;
    localparam int DIV_QBITS = TFRAC + 2;

    // Input queue depth (power of two)
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes
    localparam logic [2:0] CFG_ICON_SIZE   = 3'd0;
    localparam logic [2:0] CFG_FILL_MODE   = 3'd1;
    localparam logic [2:0] CFG_COLOR_START = 3'd2;
    localparam logic [2:0] CFG_COLOR_END   = 3'd3;

    // Gradient kinds
    localparam logic [1:0] FILL_SOLID    = 2'd0;
    localparam logic [1:0] FILL_VERTICAL = 2'd1;
    localparam logic [1:0] FILL_DIAGONAL = 2'd2;
    localparam logic [1:0] FILL_RADIAL   = 2'd3;

    // Classified pixel handed from the front to the geometry pipeline
    typedef struct packed {
        logic       valid;
        logic       zero;
        logic [7:0] x;
        logic [7:0] y;
    } pix_t;

endpackage

/* hdl/rhex_front.sv */
// ---------------------------------------------------------------------------
// Rounded hexagon front end
// Accepts pixel transactions, flags pixels outside the icon, and queues them.
// ---------------------------------------------------------------------------
`include "rounded_hexagon_icon_shader_defines.svh"

module rhex_front
    import rhex_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] pixel_x,
    input  logic [7:0] pixel_y,
    input  logic [7:0] icon_size,
    input  logic       take,
    output pix_t       head
);

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic          front_valid_reg;
    pix_t          front_reg;
    pix_t          mem [0:DEPTH-1];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          full;
    logic          push;
    logic          pop;
    logic          zero;

    // Classify: zero size or pixel beyond the icon renders as blank
    assign zero = (icon_size == 8'd0) || (pixel_x >= icon_size) || (pixel_y >= icon_size);

    assign full     = (count_reg == CW'(DEPTH));
    assign in_stall = front_valid_reg & full;
    assign push     = front_valid_reg & ~full;
    assign pop      = take & (count_reg != '0);

    // Hold the accepted transaction until the queue has room
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            front_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            front_reg <= '{valid: 1'b1, zero: zero, x: pixel_x, y: pixel_y};
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= front_reg;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        head       = mem[rd_ptr_reg];
        head.valid = (count_reg != '0);
    end

    `RHEX_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(DEPTH), "queue count overflow")
    `RHEX_ASSERT_NXT(a_stall_holds, in_stall, front_valid_reg, "stalled front lost its item")
    `RHEX_ASSERT_NXT(a_push_count, push && !pop, count_reg == $past(count_reg) + CW'(1),
                     "queue count missed a push")

endmodule

/* hdl/rhex_geom.sv */
// ---------------------------------------------------------------------------
// Rounded hexagon geometry pipeline
// Six stages from pixel to the squared hexagon and radial distances.
// ---------------------------------------------------------------------------
module rhex_geom
    import rhex_pkg::*;
#(
    parameter int F = COORD_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  pix_t                 pin,
    input  logic [7:0]           icon_size,
    output logic                 out_valid,
    output logic                 zero,
    output logic                 ypos,
    output logic signed [F+10:0] rc,
    output logic signed [F+10:0] cx,
    output logic signed [F+10:0] cy,
    output logic signed [F+10:0] den,
    output logic [2*F+19:0]      hex_sq,
    output logic [2*F+19:0]      rad_sq
);

    localparam int GW  = F + 11;
    localparam int SQW = 2 * F + 20;
    localparam logic signed [GW-1:0] HALF_PIX = GW'(1) << (F - 1);

    typedef struct packed {
        logic                 zero;
        logic signed [GW-1:0] a;
        logic signed [GW-1:0] rc;
        logic signed [GW-1:0] hx;
        logic signed [GW-1:0] hy;
        logic signed [GW-1:0] lim;
        logic signed [GW-1:0] d;
        logic signed [GW-1:0] cx;
        logic signed [GW-1:0] cy;
        logic signed [GW-1:0] dx;
        logic signed [GW-1:0] dy;
        logic signed [GW-1:0] den;
        logic [SQW-1:0]       rs;
    } geo_t;

    // Product with a 16-fraction-bit constant, rounded half away from zero
    function automatic logic signed [GW-1:0] mulk(input logic signed [GW-1:0] a,
                                                  input logic [16:0] k);
        logic [GW-1:0]  mag;
        logic [GW+16:0] p;
        logic [GW+16:0] r;
        mag  = a[GW-1] ? $unsigned(-a) : $unsigned(a);
        p    = (GW+17)'(mag) * (GW+17)'(k);
        r    = (p + (GW+17)'(K_HALF)) >> 16;
        mulk = a[GW-1] ? -$signed(r[GW-1:0]) : $signed(r[GW-1:0]);
    endfunction

    function automatic logic [SQW-1:0] sq(input logic signed [GW-1:0] a);
        logic signed [2*GW-1:0] p;
        p  = a * a;
        sq = p[SQW-1:0];
    endfunction

    logic [5:1]           vld_reg;
    geo_t                 g1_reg, g2_reg, g3_reg, g4_reg, g5_reg;
    geo_t                 g1_next, g2_next, g3_next, g4_next, g5_next;
    logic                 zero_reg, ypos_reg;
    logic signed [GW-1:0] rc_reg, cx_reg, cy_reg, den_reg;
    logic [SQW-1:0]       hs_reg, rs_reg;
    logic                 ov_reg;

    // Stage 1: centre the pixel, corner radius, radial offsets
    always_comb
    begin
        logic signed [GW-1:0] sizef;
        logic signed [GW-1:0] half;
        logic signed [GW-1:0] r0;
        logic signed [GW-1:0] px;
        logic signed [GW-1:0] py;
        sizef        = $signed({3'b000, icon_size, F'(0)});
        half         = sizef >>> 1;
        r0           = half - HALF_PIX;
        g1_next      = '0;
        g1_next.zero = pin.zero;
        g1_next.cx   = $signed({3'b000, pin.x, F'(0)}) + HALF_PIX;
        g1_next.cy   = $signed({3'b000, pin.y, F'(0)}) + HALF_PIX;
        px           = g1_next.cx - half;
        py           = g1_next.cy - half;
        g1_next.a    = r0;
        g1_next.rc   = mulk(r0, K_CORNER);
        g1_next.hx   = py[GW-1] ? -py : py;
        g1_next.hy   = px[GW-1] ? -px : px;
        g1_next.dx   = g1_next.cx - mulk(sizef, K_RCX);
        g1_next.dy   = g1_next.cy - mulk(sizef, K_RCY);
        g1_next.den  = mulk(sizef, K_RDEN);
    end

    // Stage 2: tip correction and fold across the slanted edge
    always_comb
    begin
        logic signed [GW-1:0] dot;
        g2_next   = g1_reg;
        g2_next.a = g1_reg.a + mulk(g1_reg.rc, K_TIPFIX);
        dot       = mulk(g1_reg.hy, K_HALF) - mulk(g1_reg.hx, K_SQ3H);
        g2_next.d = dot[GW-1] ? (dot <<< 1) : '0;
    end

    // Stage 3: inradius, reflected point, radial square
    always_comb
    begin
        g3_next    = g2_reg;
        g3_next.a  = mulk(g2_reg.a, K_SQ3H);
        g3_next.hx = g2_reg.hx + mulk(g2_reg.d, K_SQ3H);
        g3_next.hy = g2_reg.hy - mulk(g2_reg.d, K_HALF);
        g3_next.rs = sq(g2_reg.dx) + sq(g2_reg.dy);
    end

    // Stage 4: shrink by the corner radius, edge half length
    always_comb
    begin
        g4_next     = g3_reg;
        g4_next.a   = g3_reg.a - g3_reg.rc;
        g4_next.lim = mulk(g4_next.a, K_INVSQ3);
    end

    // Stage 5: offset from the nearest point of the flat edge
    always_comb
    begin
        logic signed [GW-1:0] cl;
        g5_next = g4_reg;
        if (g4_reg.hx < -g4_reg.lim)
        begin
            cl = -g4_reg.lim;
        end
        else if (g4_reg.hx > g4_reg.lim)
        begin
            cl = g4_reg.lim;
        end
        else
        begin
            cl = g4_reg.hx;
        end
        g5_next.hx = g4_reg.hx - cl;
        g5_next.hy = g4_reg.hy - g4_reg.a;
    end

    // Advance the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:1], pin.valid};
            ov_reg  <= vld_reg[5];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g1_reg   <= g1_next;
            g2_reg   <= g2_next;
            g3_reg   <= g3_next;
            g4_reg   <= g4_next;
            g5_reg   <= g5_next;
            // Stage 6: squared hexagon distance
            hs_reg   <= sq(g5_reg.hx) + sq(g5_reg.hy);
            ypos_reg <= (g5_reg.hy > 0);
            zero_reg <= g5_reg.zero;
            rc_reg   <= g5_reg.rc;
            cx_reg   <= g5_reg.cx;
            cy_reg   <= g5_reg.cy;
            den_reg  <= g5_reg.den;
            rs_reg   <= g5_reg.rs;
        end
    end

    assign out_valid = ov_reg;
    assign zero      = zero_reg;
    assign ypos      = ypos_reg;
    assign rc        = rc_reg;
    assign cx        = cx_reg;
    assign cy        = cy_reg;
    assign den       = den_reg;
    assign hex_sq    = hs_reg;
    assign rad_sq    = rs_reg;

endmodule

/* hdl/rhex_sqrt.sv */
// ---------------------------------------------------------------------------
// Rounded hexagon square root unit
// Two-lane pipelined integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module rhex_sqrt
    import rhex_pkg::*;
#(
    parameter int M   = COORD_BITS_DEF + 10,
    parameter int SBW = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [2*M-1:0]   a_in,
    input  logic [2*M-1:0]   b_in,
    input  logic [SBW-1:0]   sb_in,
    output logic             out_valid,
    output logic [M-1:0]     a_root,
    output logic [M-1:0]     b_root,
    output logic [SBW-1:0]   sb_out
);

    localparam int SQW = 2 * M;

    logic [M:0]     vld_reg;
    logic [SBW-1:0] sb_reg   [0:M];
    logic [SQW-1:0] n_reg    [0:1][0:M];
    logic [M+1:0]   rem_reg  [0:1][0:M];
    logic [M-1:0]   root_reg [0:1][0:M];

    // Load the operands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[M-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0]      <= sb_in;
            n_reg[0][0]    <= a_in;
            n_reg[1][0]    <= b_in;
            rem_reg[0][0]  <= '0;
            rem_reg[1][0]  <= '0;
            root_reg[0][0] <= '0;
            root_reg[1][0] <= '0;
        end
    end

    // One root bit per stage in each lane
    for (genvar k = 1; k <= M; k++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sb_reg[k] <= sb_reg[k-1];
            end
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [M+3:0] r2;
            logic [M+3:0] trial;
            logic         ge;

            always_comb
            begin
                r2    = {rem_reg[l][k-1], n_reg[l][k-1][SQW-1 -: 2]};
                trial = (M+4)'({root_reg[l][k-1], 2'b01});
                ge    = (r2 >= trial);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[l][k]    <= n_reg[l][k-1] << 2;
                    rem_reg[l][k]  <= ge ? (M+2)'(r2 - trial) : (M+2)'(r2);
                    root_reg[l][k] <= {root_reg[l][k-1][M-2:0], ge};
                end
            end
        end
    end

    assign out_valid = vld_reg[M];
    assign a_root    = root_reg[0][M];
    assign b_root    = root_reg[1][M];
    assign sb_out    = sb_reg[M];

endmodule

/* hdl/rhex_div.sv */
// ---------------------------------------------------------------------------
// Rounded hexagon gradient divider
// Pipelined restoring division giving the 16-fraction-bit gradient fraction.
// ---------------------------------------------------------------------------
module rhex_div
    import rhex_pkg::*;
#(
    parameter int VW  = COORD_BITS_DEF + 10,
    parameter int SBW = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [VW-1:0]        num,
    input  logic [VW-1:0]        dvs,
    input  logic [SBW-1:0]       sb_in,
    output logic                 out_valid,
    output logic [DIV_QBITS-1:0] quo,
    output logic [SBW-1:0]       sb_out
);

    localparam int QB = DIV_QBITS;

    logic [QB:0]    vld_reg;
    logic [SBW-1:0] sb_reg  [0:QB];
    logic [VW-1:0]  d_reg   [0:QB];
    logic [VW-1:0]  rem_reg [0:QB];
    logic [QB-1:0]  nlo_reg [0:QB];
    logic [QB-1:0]  q_reg   [0:QB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[QB-1:0], in_valid};
        end
    end

    // Load: numerator is num scaled by 2^16; its bits above QB seed the remainder
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0]  <= sb_in;
            d_reg[0]   <= dvs;
            rem_reg[0] <= num >> 2;
            nlo_reg[0] <= {num[1:0], TFRAC'(0)};
            q_reg[0]   <= '0;
        end
    end

    // One quotient bit per stage
    for (genvar k = 1; k <= QB; k++)
    begin : g_stage
        logic [VW:0] r2;
        logic        ge;

        always_comb
        begin
            r2 = {rem_reg[k-1], nlo_reg[k-1][QB-1]};
            ge = (r2 >= {1'b0, d_reg[k-1]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sb_reg[k]  <= sb_reg[k-1];
                d_reg[k]   <= d_reg[k-1];
                rem_reg[k] <= ge ? VW'(r2 - {1'b0, d_reg[k-1]}) : VW'(r2);
                nlo_reg[k] <= nlo_reg[k-1] << 1;
                q_reg[k]   <= {q_reg[k-1][QB-2:0], ge};
            end
        end
    end

    assign out_valid = vld_reg[QB];
    assign quo       = q_reg[QB];
    assign sb_out    = sb_reg[QB];

endmodule

/* hdl/rounded_hexagon_icon_shader.sv */
// ---------------------------------------------------------------------------
// Rounded hexagon icon shader
// Streams pixel coordinates of a square icon and returns BGRA colours.
// ---------------------------------------------------------------------------
// One pixel is accepted and one colour delivered every clock when neither
// side stalls. From the accepting edge to out_valid a pixel passes through
// one front register, one slot of the four-entry input queue, where it may
// wait, six geometry stages, a COORD_BITS+11 stage square root shared by
// the hexagon and radial lanes, a nineteen-stage gradient divider and the
// output register. The whole back end advances together, so an output
// stall freezes it and the queue absorbs new pixels until it fills.
// Configuration writes are always ready and should be made only while no
// pixel is in flight.
// ---------------------------------------------------------------------------
module rounded_hexagon_icon_shader
    import rhex_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  pixel_x,
    input  logic [7:0]  pixel_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  blue,
    output logic [7:0]  green,
    output logic [7:0]  red,
    output logic [7:0]  alpha,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int F    = COORD_BITS;
    localparam int GW   = F + 11;
    localparam int SQW  = 2 * F + 20;
    localparam int M    = F + 10;
    localparam int SBW1 = 2 + 4 * GW;
    localparam int SBW2 = 2 + GW;
    localparam int AW   = F + 9;
    localparam logic signed [GW-1:0] HALF_PIX = GW'(1) << (F - 1);
    localparam logic signed [GW-1:0] ONE_PIX  = GW'(1) << F;

    logic [7:0]  icon_size_reg;
    logic [1:0]  fill_mode_reg;
    logic [23:0] color_start_reg;
    logic [23:0] color_end_reg;

    logic        adv;
    pix_t        head;

    logic                 g_valid, g_zero, g_ypos;
    logic signed [GW-1:0] g_rc, g_cx, g_cy, g_den;
    logic [SQW-1:0]       g_hs, g_rs;

    logic                 s_valid;
    logic [M-1:0]         s_hroot, s_rroot;
    logic [SBW1-1:0]      s_sb;
    logic                 s_zero, s_ypos;
    logic signed [GW-1:0] s_rc, s_cx, s_cy, s_den;

    logic signed [GW-1:0] len, sd, cov;
    logic                 kill, sat;
    logic [M-1:0]         num, dvs;
    logic [F+7:0]         sizef;

    logic                 d_valid;
    logic [DIV_QBITS-1:0] d_quo;
    logic [SBW2-1:0]      d_sb;
    logic                 d_kill, d_sat;
    logic signed [GW-1:0] d_cov;

    logic                 out_valid_reg;
    logic [7:0]           blue_reg, green_reg, red_reg, alpha_reg;
    logic [16:0]          t;
    logic [AW-1:0]        ap;
    logic [7:0]           alpha_next;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            icon_size_reg   <= 8'd82;
            fill_mode_reg   <= FILL_SOLID;
            color_start_reg <= '0;
            color_end_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ICON_SIZE:   icon_size_reg   <= cfg_data[7:0];
                CFG_FILL_MODE:   fill_mode_reg   <= cfg_data[1:0];
                CFG_COLOR_START: color_start_reg <= cfg_data;
                CFG_COLOR_END:   color_end_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Back end advances whenever the output register can move
    assign adv = !out_valid_reg || !out_stall;

    rhex_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .icon_size (icon_size_reg),
        .take      (adv),
        .head      (head)
    );

    rhex_geom #(.F(F)) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .pin       (head),
        .icon_size (icon_size_reg),
        .out_valid (g_valid),
        .zero      (g_zero),
        .ypos      (g_ypos),
        .rc        (g_rc),
        .cx        (g_cx),
        .cy        (g_cy),
        .den       (g_den),
        .hex_sq    (g_hs),
        .rad_sq    (g_rs)
    );

    rhex_sqrt #(.M(M), .SBW(SBW1)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (g_valid),
        .a_in      (g_hs),
        .b_in      (g_rs),
        .sb_in     ({g_zero, g_ypos, g_rc, g_cx, g_cy, g_den}),
        .out_valid (s_valid),
        .a_root    (s_hroot),
        .b_root    (s_rroot),
        .sb_out    (s_sb)
    );

    assign {s_zero, s_ypos, s_rc, s_cx, s_cy, s_den} = s_sb;

    // Coverage from the signed distance, and divider operands per gradient kind
    assign sizef = {icon_size_reg, F'(0)};

    always_comb
    begin
        len  = $signed({1'b0, s_hroot});
        sd   = (s_ypos ? len : -len) - s_rc;
        cov  = HALF_PIX - sd;
        kill = s_zero || (cov <= 0);
        sat  = 1'b0;
        unique case (fill_mode_reg)
            FILL_SOLID:
            begin
                num = '0;
                dvs = M'(1);
            end
            FILL_VERTICAL:
            begin
                num = M'($unsigned(s_cy));
                dvs = M'(sizef);
            end
            FILL_DIAGONAL:
            begin
                num = M'($unsigned(s_cx + s_cy));
                dvs = M'({sizef, 1'b0});
            end
            FILL_RADIAL:
            begin
                num = s_rroot;
                dvs = (s_den > 0) ? M'($unsigned(s_den)) : M'(1);
                sat = (s_den <= 0);
            end
        endcase
    end

    rhex_div #(.VW(M), .SBW(SBW2)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s_valid),
        .num       (num),
        .dvs       (dvs),
        .sb_in     ({kill, sat, cov}),
        .out_valid (d_valid),
        .quo       (d_quo),
        .sb_out    (d_sb)
    );

    assign {d_kill, d_sat, d_cov} = d_sb;

    // Interpolate one channel with rounding
    function automatic logic [7:0] mix8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [16:0] tf);
        logic signed [8:0]  diff;
        logic signed [17:0] ts;
        logic signed [26:0] prod;
        logic signed [26:0] v;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        ts   = $signed({1'b0, tf});
        prod = diff * ts;
        v    = $signed({3'b000, a, 16'h0000}) + prod + 27'sd32768;
        mix8 = v[23:16];
    endfunction

    // Clamp t and work out alpha
    always_comb
    begin
        if (d_sat || (d_quo > DIV_QBITS'(K_ONE)))
        begin
            t = K_ONE;
        end
        else
        begin
            t = d_quo[16:0];
        end
        ap = AW'(d_cov[F-1:0]) * AW'(8'd255) + (AW'(1) << (F - 1));
        if (d_cov >= ONE_PIX)
        begin
            alpha_next = 8'd255;
        end
        else
        begin
            alpha_next = ap[F+7:F];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && d_valid)
        begin
            if (d_kill)
            begin
                blue_reg  <= '0;
                green_reg <= '0;
                red_reg   <= '0;
                alpha_reg <= '0;
            end
            else
            begin
                blue_reg  <= mix8(color_start_reg[7:0], color_end_reg[7:0], t);
                green_reg <= mix8(color_start_reg[15:8], color_end_reg[15:8], t);
                red_reg   <= mix8(color_start_reg[23:16], color_end_reg[23:16], t);
                alpha_reg <= alpha_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign blue      = blue_reg;
    assign green     = green_reg;
    assign red       = red_reg;
    assign alpha     = alpha_reg;

endmodule
